// ===== hw/rtl/brf_pkg.sv =====
// ---------------------------------------------------------------------------
// brf_pkg: shared types and codes for the ring byte FIFO unit.
// Holds the item formats, operation and status codes, and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package brf_pkg;

  // Width of a message length and of a run length.
  localparam int LEN_W = 7;
  // Width of the reported fill count.
  localparam int FILL_W = 11;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_TOO_FEW  = 3'd2,
    ST_NO_MSG   = 3'd3,
    ST_LQ_FULL  = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [7:0]       data_in;
    logic             end_of_message;
    logic             framed;
    logic [LEN_W-1:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic              last_of_run;
    status_t           status;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the accepted item into the item register
    logic exec;       // carry out the held item's operation
    logic emit_byte;  // send the byte read from the store
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic get_run;    // the held item is a get that emits a run of bytes
    logic out_free;   // the output register can take a result this cycle
    logic last_byte;  // the byte now read out is the final one of its run
  } ctl_sts_t;

endpackage

// ===== hw/rtl/brf_ram.sv =====
// ---------------------------------------------------------------------------
// brf_ram: generic single-port-write, single-port-read RAM.
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/brf_ctrl.sv =====
// ---------------------------------------------------------------------------
// brf_ctrl: sequencing state machine of the ring byte FIFO unit.
// Accepts one item, has the datapath execute it, and steps a get run out
// one byte at a time as the output register frees up.
// ---------------------------------------------------------------------------
module brf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  brf_pkg::ctl_sts_t sts,
  output brf_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd = '0;
    cmd.capture   = in_valid && in_ready_r;
    cmd.exec      = (state_r == S_EXEC) && sts.out_free;
    cmd.emit_byte = (state_r == S_EMIT) && sts.out_free;
  end

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt    = S_EXEC;
          in_ready_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          if (sts.get_run) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt    = S_IDLE;
            in_ready_nxt = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (cmd.emit_byte && sts.last_byte) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

`ifndef SYNTHESIS
  // An accepted item blocks the input until its results are produced.
  a_capture_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready_r)
    else $error("input still ready after an item was accepted");

  // Sending the final byte of a run reopens the input.
  a_run_end_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_byte && sts.last_byte) |=> in_ready_r)
    else $error("input not reopened after the end of a run");
`endif

endmodule

// ===== hw/rtl/brf_datapath.sv =====
// ---------------------------------------------------------------------------
// brf_datapath: storage, pointers, counters and output register of the
// ring byte FIFO unit. Holds the byte store and the message length queue
// and works out each operation's status and effect.
// ---------------------------------------------------------------------------
module brf_datapath #(
  parameter int STORE_DEPTH        = 1024,
  parameter int LENGTH_QUEUE_DEPTH = 32,
  parameter int MAX_MESSAGE        = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  brf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output brf_pkg::out_item_t out_item,
  input  brf_pkg::ctl_cmd_t  cmd,
  output brf_pkg::ctl_sts_t  sts
);

  localparam int LW   = brf_pkg::LEN_W;
  localparam int SAW  = $clog2(STORE_DEPTH);
  localparam int BHW  = $clog2(STORE_DEPTH + 1);
  localparam int QAW  = $clog2(LENGTH_QUEUE_DEPTH);
  localparam int QHW  = $clog2(LENGTH_QUEUE_DEPTH + 1);
  localparam int CMPW = (BHW > LW) ? BHW : LW;

  brf_pkg::in_item_t  item_r;
  brf_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [SAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [BHW-1:0] bytes_held_r, bytes_held_nxt;
  logic [QAW-1:0] lq_head_r, lq_head_nxt, lq_tail_r, lq_tail_nxt;
  logic [QHW-1:0] lengths_held_r, lengths_held_nxt;
  logic [LW-1:0]  cur_msg_r, cur_msg_nxt;
  logic [LW-1:0]  rem_r, rem_nxt;

  logic [SAW-1:0] wp_inc, rp_inc;
  logic [QAW-1:0] head_inc, tail_inc;
  logic [7:0]     bs_rd_data;
  logic [LW-1:0]  lq_rd_data;
  logic [LW-1:0]  sel_len, get_len;
  logic [LW-1:0]  msg_len;

  brf_pkg::status_t put_status, get_status, single_status;
  logic put_ok, get_ok, get_start, pop, push, read_next, do_clear;
  logic load_single, load_byte, bs_rd_en;

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // Wrapping increments of the pointers.
  assign wp_inc   = (wp_r == SAW'(STORE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc   = (rp_r == SAW'(STORE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign head_inc = (lq_head_r == QAW'(LENGTH_QUEUE_DEPTH - 1)) ? '0 : lq_head_r + 1'b1;
  assign tail_inc = (lq_tail_r == QAW'(LENGTH_QUEUE_DEPTH - 1)) ? '0 : lq_tail_r + 1'b1;

  // Put checks, in order of precedence.
  always_comb begin
    if (bytes_held_r >= BHW'(STORE_DEPTH)) begin
      put_status = brf_pkg::ST_FULL;
    end else if (item_r.framed && (cur_msg_r >= LW'(MAX_MESSAGE))) begin
      put_status = brf_pkg::ST_TOO_LONG;
    end else if (item_r.framed && item_r.end_of_message &&
                 (lengths_held_r >= QHW'(LENGTH_QUEUE_DEPTH))) begin
      put_status = brf_pkg::ST_LQ_FULL;
    end else begin
      put_status = brf_pkg::ST_OK;
    end
  end

  // Run length: the queue head in framed mode, else the input, saturated.
  assign sel_len = item_r.framed ? lq_rd_data : item_r.run_length;
  assign get_len = (sel_len > LW'(MAX_MESSAGE)) ? LW'(MAX_MESSAGE) : sel_len;

  // Get checks.
  always_comb begin
    if (item_r.framed && (lengths_held_r == '0)) begin
      get_status = brf_pkg::ST_NO_MSG;
    end else if (CMPW'(get_len) > CMPW'(bytes_held_r)) begin
      get_status = brf_pkg::ST_TOO_FEW;
    end else begin
      get_status = brf_pkg::ST_OK;
    end
  end

  // Status of a single-result operation.
  always_comb begin
    case (item_r.operation)
      brf_pkg::OP_PUT: single_status = put_status;
      brf_pkg::OP_GET: single_status = get_status;
      default:         single_status = brf_pkg::ST_OK;
    endcase
  end

  // Operation strobes.
  assign put_ok    = cmd.exec && (item_r.operation == brf_pkg::OP_PUT) &&
                     (put_status == brf_pkg::ST_OK);
  assign get_ok    = cmd.exec && (item_r.operation == brf_pkg::OP_GET) &&
                     (get_status == brf_pkg::ST_OK);
  assign get_start = get_ok && (get_len != '0);
  assign pop       = get_ok && item_r.framed;
  assign push      = put_ok && item_r.framed && item_r.end_of_message;
  assign do_clear  = cmd.exec && (item_r.operation == brf_pkg::OP_CLEAR);
  assign read_next = cmd.emit_byte && (rem_r != LW'(1));
  assign bs_rd_en  = get_start || read_next;
  assign msg_len   = cur_msg_r + 1'b1;

  // Next values of pointers and counters.
  always_comb begin
    wp_nxt           = wp_r;
    rp_nxt           = rp_r;
    bytes_held_nxt   = bytes_held_r;
    lq_head_nxt      = lq_head_r;
    lq_tail_nxt      = lq_tail_r;
    lengths_held_nxt = lengths_held_r;
    cur_msg_nxt      = cur_msg_r;
    rem_nxt          = rem_r;
    if (do_clear) begin
      wp_nxt           = '0;
      rp_nxt           = '0;
      bytes_held_nxt   = '0;
      lq_head_nxt      = '0;
      lq_tail_nxt      = '0;
      lengths_held_nxt = '0;
      cur_msg_nxt      = '0;
    end
    if (put_ok) begin
      wp_nxt         = wp_inc;
      bytes_held_nxt = bytes_held_r + 1'b1;
      if (item_r.framed) begin
        cur_msg_nxt = item_r.end_of_message ? '0 : msg_len;
      end
    end
    if (push) begin
      lq_tail_nxt      = tail_inc;
      lengths_held_nxt = lengths_held_r + 1'b1;
    end
    if (pop) begin
      lq_head_nxt      = head_inc;
      lengths_held_nxt = lengths_held_r - 1'b1;
    end
    if (get_start) begin
      bytes_held_nxt = BHW'(CMPW'(bytes_held_r) - CMPW'(get_len));
      rem_nxt        = get_len;
    end
    if (bs_rd_en) begin
      rp_nxt = rp_inc;
    end
    if (read_next) begin
      rem_nxt = rem_r - 1'b1;
    end
  end

  // Output register: single results and bytes of a run.
  assign load_single = cmd.exec && !get_start;
  assign load_byte   = cmd.emit_byte;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.get_run   = (item_r.operation == brf_pkg::OP_GET) &&
                         (get_status == brf_pkg::ST_OK) && (get_len != '0);
  assign sts.last_byte = (rem_r == LW'(1));

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load_single) begin
      out_item_nxt.data_out    = '0;
      out_item_nxt.last_of_run = 1'b1;
      out_item_nxt.status      = single_status;
      out_item_nxt.fill_count  = brf_pkg::FILL_W'(bytes_held_nxt);
      out_valid_nxt            = 1'b1;
    end else if (load_byte) begin
      out_item_nxt.data_out    = bs_rd_data;
      out_item_nxt.last_of_run = sts.last_byte;
      out_item_nxt.status      = brf_pkg::ST_OK;
      out_item_nxt.fill_count  = brf_pkg::FILL_W'(bytes_held_nxt);
      out_valid_nxt            = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r           <= '0;
      rp_r           <= '0;
      bytes_held_r   <= '0;
      lq_head_r      <= '0;
      lq_tail_r      <= '0;
      lengths_held_r <= '0;
      cur_msg_r      <= '0;
      rem_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      wp_r           <= wp_nxt;
      rp_r           <= rp_nxt;
      bytes_held_r   <= bytes_held_nxt;
      lq_head_r      <= lq_head_nxt;
      lq_tail_r      <= lq_tail_nxt;
      lengths_held_r <= lengths_held_nxt;
      cur_msg_r      <= cur_msg_nxt;
      rem_r          <= rem_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Byte store.
  brf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_byte_store (
    .clk     (clk),
    .wr_en   (put_ok),
    .wr_addr (wp_r),
    .wr_data (item_r.data_in),
    .rd_en   (bs_rd_en),
    .rd_addr (rp_r),
    .rd_data (bs_rd_data)
  );

  // Message length queue; the head entry is read continuously.
  brf_ram #(
    .WIDTH (LW),
    .DEPTH (LENGTH_QUEUE_DEPTH)
  ) u_length_queue (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (lq_tail_r),
    .wr_data (msg_len),
    .rd_en   (1'b1),
    .rd_addr (lq_head_r),
    .rd_data (lq_rd_data)
  );

`ifndef SYNTHESIS
  // The fill count never exceeds the store size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_held_r <= BHW'(STORE_DEPTH))
    else $error("byte count beyond store depth");

  // The length count never exceeds the queue size.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lengths_held_r <= QHW'(LENGTH_QUEUE_DEPTH))
    else $error("length count beyond queue depth");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load_single || load_byte) |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");
`endif

endmodule

// ===== hw/rtl/byte_ring_fifo_with_message_lengths_unit.sv =====
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_message_lengths_unit: circular byte FIFO with a queue
// of message lengths for framed traffic.
// ---------------------------------------------------------------------------
// Each accepted item is executed one at a time. For put, clear and query,
// the item is taken, then executed and its result loaded, before the next
// item can be accepted. A get that delivers a run of bytes is taken, then
// checked and its first read started, then sends one byte per cycle while
// the output is free, paced by the registered read port of the byte store.
// The output register holds a finished result while the next item is taken;
// a stalled output stalls the run. Refused operations give one result with
// a nonzero status and change nothing.
// There is no clearing pass after reset; the unit is ready at once.
// ---------------------------------------------------------------------------
module byte_ring_fifo_with_message_lengths_unit #(
  parameter int STORE_DEPTH        = 1024,
  parameter int LENGTH_QUEUE_DEPTH = 32,
  parameter int MAX_MESSAGE        = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  brf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output brf_pkg::out_item_t out_item
);

  brf_pkg::ctl_cmd_t cmd;
  brf_pkg::ctl_sts_t sts;

  // Sequencing.
  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and result path.
  brf_datapath #(
    .STORE_DEPTH        (STORE_DEPTH),
    .LENGTH_QUEUE_DEPTH (LENGTH_QUEUE_DEPTH),
    .MAX_MESSAGE        (MAX_MESSAGE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
